[rtl/ppd_pkg.sv]
// Shared types, codes and helpers for the preemptive priority dispatcher.
package ppd_pkg;

  // Default table depth
  localparam int unsigned TASK_SLOTS_DEF = 16;

  // Fixed field widths
  localparam int unsigned SLOT_FW  = 4;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned BURST_W  = 10;
  localparam int unsigned IN_DW    = 56;
  localparam int unsigned OUT_DW   = 24;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_RESUME = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_FINISH = 2'd3
  } act_t;

  // One task table entry
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
  } entry_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_STOP,
    ST_GO,
    ST_DEC,
    ST_FIN
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic scan;
    logic scan_end;
    logic decide;
    logic emit_stop;
    logic emit_go;
    logic dec;
    logic emit_fin;
  } ppd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_tick;
    logic scan_last;
    logic stop_need;
    logic go_need;
    logic fin_need;
    logic out_free;
  } ppd_status_t;

  // a wins over b: higher priority, then less remaining time
  function automatic logic beats(input entry_t a, input entry_t b);
    logic res;
    res = (a.prio > b.prio) || ((a.prio == b.prio) && (a.remaining < b.remaining));
    return res;
  endfunction

endpackage

[rtl/preemptive_priority_dispatcher_unit.sv]
// Top level of the preemptive priority dispatcher: controller plus datapath.
// A load word is captured, then written into the task table. A tick word walks the task
// table one slot per cycle through the table memory's single read port to reach a
// decision, then emits its results (stop, start/resume, finish; 0 to 3 of them), each
// of which can wait on a stall of the result side, and does one countdown step. A new
// word is accepted while the last result of the previous one still sits in the output
// register. Results of one tick arrive in order stop, start/resume, finish, with
// tlast on the final one.
module preemptive_priority_dispatcher_unit #(
  parameter int unsigned TASK_SLOTS = ppd_pkg::TASK_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // slot[3:0], priority_req[11:4], arrival[27:12], burst_len[37:28],
  // tick_now[53:38], zero pad[55:54]
  input  logic [ppd_pkg::IN_DW-1:0]  in_tdata,
  // operation[0]
  input  logic [0:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // task_slot[3:0], burst[13:4], remaining[23:14]
  output logic [ppd_pkg::OUT_DW-1:0] out_tdata,
  // action[1:0]
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);
  import ppd_pkg::*;

  ppd_cmd_t    cmd;
  ppd_status_t status;

  ppd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ppd_dpath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/ppd_ctrl.sv]
// Sequencer for load, scan, dispatch and countdown of the dispatcher.
module ppd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ppd_pkg::ppd_status_t status,
  output ppd_pkg::ppd_cmd_t    cmd
);
  import ppd_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = status.in_tick ? ST_SCAN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        // last compare and running entry read share this cycle
        cmd.scan_end = 1'b1;
        state_nxt    = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_DEC;
        if (status.stop_need) begin
          state_nxt = ST_STOP;
        end else if (status.go_need) begin
          state_nxt = ST_GO;
        end
      end
      ST_STOP: begin
        if (status.out_free) begin
          cmd.emit_stop = 1'b1;
          state_nxt     = ST_GO;
        end
      end
      ST_GO: begin
        if (status.out_free) begin
          cmd.emit_go = 1'b1;
          state_nxt   = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd.dec   = 1'b1;
        state_nxt = status.fin_need ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.emit_fin = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/ppd_dpath.sv]
// Task table, scan compare, running-task registers and result register.
module ppd_dpath #(
  parameter int unsigned TASK_SLOTS = ppd_pkg::TASK_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ppd_pkg::ppd_cmd_t           cmd,
  output ppd_pkg::ppd_status_t        status,
  input  logic [ppd_pkg::IN_DW-1:0]  in_tdata,
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ppd_pkg::OUT_DW-1:0] out_tdata,
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);
  import ppd_pkg::*;

  localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);

  // Captured input word
  logic [SLOT_FW-1:0] slot_r;
  logic [PRIO_W-1:0]  prio_r;
  logic [TIME_W-1:0]  arr_r;
  logic [BURST_W-1:0] burst_r;
  logic [TIME_W-1:0]  now_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_r  <= in_tdata[3:0];
      prio_r  <= in_tdata[11:4];
      arr_r   <= in_tdata[27:12];
      burst_r <= in_tdata[37:28];
      now_r   <= in_tdata[53:38];
    end
  end

  // Per-slot flags and running task
  logic [TASK_SLOTS-1:0] valid_r, done_r, started_r;
  logic                  run_valid_r;
  logic [SLOT_W-1:0]     run_slot_r;

  // Scan state
  logic [SLOT_W-1:0] cnt_r, cmp_idx_r, best_idx_r;
  logic              cmp_v_r, found_r;
  entry_t            best_e_r, run_e_r, cur_e_r;
  logic              go_r, fin_r;

  // Task table memory
  entry_t            mem [TASK_SLOTS];
  entry_t            rd_q_r, wr_data;
  logic              rd_en, wr_en;
  logic [SLOT_W-1:0] rd_addr, wr_addr, ld_idx;
  logic              ld_ok;

  assign ld_idx  = SLOT_W'(slot_r);
  assign ld_ok   = ({5'd0, slot_r} < 9'(TASK_SLOTS));
  assign rd_en   = cmd.scan | cmd.scan_end;
  assign rd_addr = cmd.scan ? cnt_r : run_slot_r;

  // Write port: load fills an entry, countdown rewrites the running one
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ld_idx;
    wr_data = '{prio: prio_r, arrival: arr_r, burst: burst_r, remaining: burst_r};
    if (cmd.load) begin
      wr_en = ld_ok;
    end else if (cmd.dec) begin
      wr_en             = run_valid_r;
      wr_addr           = run_slot_r;
      wr_data           = cur_e_r;
      wr_data.remaining = (cur_e_r.remaining <= BURST_W'(1)) ? '0
                        : cur_e_r.remaining - BURST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Scan compare on the registered read word
  logic elig;
  assign elig = valid_r[cmp_idx_r] & ~done_r[cmp_idx_r] & (rd_q_r.arrival <= now_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      cmp_v_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      cmp_v_r <= cmd.scan;
      if (cmd.capture) begin
        cnt_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.scan) begin
          cnt_r <= cnt_r + SLOT_W'(1);
        end
        if (cmp_v_r && elig && (!found_r || beats(rd_q_r, best_e_r))) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cnt_r;
    if (cmp_v_r && elig && (!found_r || beats(rd_q_r, best_e_r))) begin
      best_e_r   <= rd_q_r;
      best_idx_r <= cmp_idx_r;
    end
  end

  // Dispatch decision; rd_q_r holds the running entry here
  logic beat_run, go_c, stop_c;
  entry_t after_e;
  assign beat_run = (best_idx_r != run_slot_r) && beats(best_e_r, rd_q_r);
  assign go_c     = found_r && (!run_valid_r || beat_run);
  assign stop_c   = found_r && run_valid_r && beat_run;
  assign after_e  = go_c ? best_e_r : rd_q_r;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      go_r    <= go_c;
      fin_r   <= (run_valid_r || go_c) && (after_e.remaining <= BURST_W'(1));
      run_e_r <= rd_q_r;
      cur_e_r <= after_e;
    end
  end

  // Flags and running task updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      done_r      <= '0;
      started_r   <= '0;
      run_valid_r <= 1'b0;
      run_slot_r  <= '0;
    end else begin
      if (cmd.load && ld_ok) begin
        valid_r[ld_idx]   <= 1'b1;
        done_r[ld_idx]    <= 1'b0;
        started_r[ld_idx] <= 1'b0;
        if (run_valid_r && (run_slot_r == ld_idx)) begin
          run_valid_r <= 1'b0;
        end
      end
      if (cmd.emit_go) begin
        started_r[best_idx_r] <= 1'b1;
        run_valid_r           <= 1'b1;
        run_slot_r            <= best_idx_r;
      end
      if (cmd.dec && run_valid_r && (cur_e_r.remaining <= BURST_W'(1))) begin
        done_r[run_slot_r] <= 1'b1;
        run_valid_r        <= 1'b0;
      end
    end
  end

  // Result register
  logic               out_valid_r, out_last_r;
  act_t               out_act_r;
  logic [SLOT_FW-1:0] out_slot_r;
  logic [BURST_W-1:0] out_burst_r, out_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_stop || cmd.emit_go || cmd.emit_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_stop) begin
      out_act_r   <= ACT_STOP;
      out_slot_r  <= SLOT_FW'(run_slot_r);
      out_burst_r <= run_e_r.burst;
      out_rem_r   <= run_e_r.remaining;
      out_last_r  <= ~go_r & ~fin_r;
    end else if (cmd.emit_go) begin
      out_act_r   <= started_r[best_idx_r] ? ACT_RESUME : ACT_START;
      out_slot_r  <= SLOT_FW'(best_idx_r);
      out_burst_r <= best_e_r.burst;
      out_rem_r   <= best_e_r.remaining;
      out_last_r  <= ~fin_r;
    end else if (cmd.emit_fin) begin
      out_act_r   <= ACT_FINISH;
      out_slot_r  <= SLOT_FW'(run_slot_r);
      out_burst_r <= cur_e_r.burst;
      out_rem_r   <= '0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rem_r, out_burst_r, out_slot_r};
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;

  // Status to controller
  assign status.in_tick   = in_tuser;
  assign status.scan_last = (cnt_r == SLOT_W'(TASK_SLOTS - 1));
  assign status.stop_need = stop_c;
  assign status.go_need   = go_c;
  assign status.fin_need  = fin_r;
  assign status.out_free  = ~out_valid_r | out_tready;

endmodule

[bench/testbench.sv]
// Self-checking bench for the preemptive priority dispatcher unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ppd_pkg::*;

  localparam int NSLOTS      = TASK_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 40;
  localparam bit OP_LOAD     = 1'b0;
  localparam bit OP_TICK     = 1'b1;

  // One expected dispatcher action
  typedef struct {
    act_t               action;
    logic [SLOT_FW-1:0] slot;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] left;
    logic               last;
  } dispatch_evt_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;
  logic [0:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic [1:0]          out_tuser;
  logic                out_tlast;

  // Shadow task table
  bit                  tab_valid   [NSLOTS];
  bit                  tab_done    [NSLOTS];
  bit                  tab_started [NSLOTS];
  logic [PRIO_W-1:0]   tab_prio    [NSLOTS];
  logic [TIME_W-1:0]   tab_arrival [NSLOTS];
  logic [BURST_W-1:0]  tab_burst   [NSLOTS];
  logic [BURST_W-1:0]  tab_left    [NSLOTS];
  bit                  run_valid;
  int                  run_slot;

  dispatch_evt_t       pending_actions[$];
  dispatch_evt_t       want;
  int                  mismatch_count;
  int                  words_sent;
  int                  actions_seen;
  int                  act_hits[4];
  int                  cycle_count;
  bit                  no_idle;
  logic [TIME_W-1:0]   sim_now;

  preemptive_priority_dispatcher_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d actions still pending",
             cycle_count, pending_actions.size());
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("%0t ERROR %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    mismatch_count++;
  endtask

  // a displaces b: higher priority, then less time left
  function automatic bit outranks(int a, int b);
    return (tab_prio[a] > tab_prio[b]) ||
           ((tab_prio[a] == tab_prio[b]) && (tab_left[a] < tab_left[b]));
  endfunction

  task automatic expect_action(act_t act, int s, logic [BURST_W-1:0] left, bit last);
    dispatch_evt_t e;
    e.action = act;
    e.slot   = s[SLOT_FW-1:0];
    e.burst  = tab_burst[s];
    e.left   = left;
    e.last   = last;
    pending_actions.push_back(e);
  endtask

  // Predict the actions caused by one accepted word
  task automatic apply_word(bit op, logic [SLOT_FW-1:0] s, logic [PRIO_W-1:0] p,
                            logic [TIME_W-1:0] arr, logic [BURST_W-1:0] bst,
                            logic [TIME_W-1:0] now);
    int                 best;
    int                 old_run;
    int                 fin_slot;
    bit                 found;
    bit                 do_stop;
    bit                 do_go;
    bit                 do_fin;
    logic [BURST_W-1:0] stop_left;
    logic [BURST_W-1:0] go_left;
    act_t               go_act;
    if (op == OP_LOAD) begin
      tab_valid[s]   = 1'b1;
      tab_prio[s]    = p;
      tab_arrival[s] = arr;
      tab_burst[s]   = bst;
      tab_left[s]    = bst;
      tab_done[s]    = 1'b0;
      tab_started[s] = 1'b0;
      // reloading the running slot drops it without a stop
      if (run_valid && run_slot == int'(s)) run_valid = 1'b0;
    end else begin
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < NSLOTS; i++) begin
        if (tab_valid[i] && !tab_done[i] && tab_arrival[i] <= now) begin
          if (!found || outranks(i, best)) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      do_stop = 1'b0;
      do_go   = 1'b0;
      if (found) begin
        if (!run_valid) begin
          do_go = 1'b1;
        end else if (best != run_slot && outranks(best, run_slot)) begin
          do_stop = 1'b1;
          do_go   = 1'b1;
        end
      end
      if (do_stop) begin
        old_run   = run_slot;
        stop_left = tab_left[old_run];
      end
      if (do_go) begin
        go_act           = tab_started[best] ? ACT_RESUME : ACT_START;
        go_left          = tab_left[best];
        tab_started[best] = 1'b1;
        run_valid        = 1'b1;
        run_slot         = best;
      end
      // countdown; zero or one left finishes without wrapping
      do_fin = 1'b0;
      if (run_valid) begin
        fin_slot = run_slot;
        if (tab_left[fin_slot] <= 1) begin
          tab_left[fin_slot] = '0;
          tab_done[fin_slot] = 1'b1;
          run_valid          = 1'b0;
          do_fin             = 1'b1;
        end else begin
          tab_left[fin_slot] = tab_left[fin_slot] - 1'b1;
        end
      end
      if (do_stop) expect_action(ACT_STOP, old_run, stop_left, 1'b0);
      if (do_go)   expect_action(go_act, best, go_left, !do_fin);
      if (do_fin)  expect_action(ACT_FINISH, fin_slot, '0, 1'b1);
    end
  endtask

  // Drive one word after a random gap and wait for it to be taken
  task automatic send_word(bit op, logic [SLOT_FW-1:0] s, logic [PRIO_W-1:0] p,
                           logic [TIME_W-1:0] arr, logic [BURST_W-1:0] bst,
                           logic [TIME_W-1:0] now);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {2'b00, now, bst, arr, p, s};
    do @(posedge clk); while (!in_tready);
    apply_word(op, s, p, arr, bst, now);
    words_sent++;
  endtask

  // Drop valid, let all expected actions come out, then settle
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly a plausible workload around the running clock, some noise
  task automatic send_random_word();
    logic [PRIO_W-1:0]  p;
    logic [TIME_W-1:0]  arr;
    logic [BURST_W-1:0] bst;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      p   = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(0, 3) * 8);
      arr = ($urandom_range(0, 99) < 85) ? sim_now + TIME_W'($urandom_range(0, 6))
                                         : TIME_W'($urandom);
      bst = ($urandom_range(0, 9) != 0) ? BURST_W'($urandom_range(0, 8))
                                        : BURST_W'($urandom_range(0, 1023));
      send_word(OP_LOAD, SLOT_FW'($urandom), p, arr, bst, TIME_W'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 90)      sim_now = sim_now + TIME_W'($urandom_range(0, 3));
      else if (pick < 95) sim_now = sim_now - TIME_W'($urandom_range(1, 20));
      else                sim_now = TIME_W'($urandom);
      send_word(OP_TICK, SLOT_FW'($urandom), PRIO_W'($urandom), TIME_W'($urandom),
                BURST_W'($urandom), sim_now);
    end
  endtask

  // Field extremes and each corner of the dispatch rules
  task automatic test_directed();
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd0);          // empty table
    send_word(OP_LOAD, 4'd15, 8'd0, 16'hFFFF, 10'd1023, 16'hFFFF);
    send_word(OP_LOAD, 4'd0, 8'd255, 16'd0, 10'd0, 16'd0);        // zero burst
    send_word(OP_TICK, 4'd15, 8'd255, 16'hFFFF, 10'd1023, 16'd0);
    send_word(OP_LOAD, 4'd1, 8'd10, 16'd0, 10'd3, 16'd0);
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd1);
    send_word(OP_LOAD, 4'd2, 8'd20, 16'd0, 10'd2, 16'd0);
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd2);          // preempt by priority
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd3);          // picked is running
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd4);          // resume
    send_word(OP_LOAD, 4'd3, 8'd10, 16'd0, 10'd0, 16'd0);
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd5);          // preempt on time left
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd6);
    send_word(OP_LOAD, 4'd4, 8'd5, 16'd0, 10'd5, 16'd0);
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd7);
    send_word(OP_LOAD, 4'd4, 8'd5, 16'd0, 10'd5, 16'd0);          // reload running slot
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd8);
    send_word(OP_LOAD, 4'd5, 8'd100, 16'd1000, 10'd4, 16'd0);
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd1000);
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd10);         // time went back
    send_word(OP_LOAD, 4'd6, 8'd200, 16'd0, 10'd2, 16'd0);
    send_word(OP_LOAD, 4'd7, 8'd200, 16'd0, 10'd2, 16'd0);        // full tie, lower slot wins
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'd11);
    send_word(OP_TICK, 4'd0, 8'd0, 16'd0, 10'd0, 16'hFFFF);
    wait_drained();
  endtask

  // Words back to back on both sides
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (40) send_random_word();
    wait_drained();
    no_idle = 1'b0;
  endtask

  // Long random workload with a full drain halfway
  task automatic test_random_workload();
    repeat (175) send_random_word();
    wait_drained();
    repeat (175) send_random_word();
    wait_drained();
  endtask

  // Result side: random stall before each word
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Compare each result word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      actions_seen++;
      if (pending_actions.size() == 0) begin
        report_mismatch("result with nothing expected, action", out_tuser, -1);
      end else begin
        want = pending_actions.pop_front();
        act_hits[want.action]++;
        if (out_tuser != want.action)
          report_mismatch("action", out_tuser, want.action);
        if (out_tdata[3:0] != want.slot)
          report_mismatch("task_slot", out_tdata[3:0], want.slot);
        if (out_tdata[13:4] != want.burst)
          report_mismatch("burst", out_tdata[13:4], want.burst);
        if (out_tdata[23:14] != want.left)
          report_mismatch("remaining", out_tdata[23:14], want.left);
        if (out_tlast != want.last)
          report_mismatch("tlast", out_tlast, want.last);
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    no_idle        = 1'b0;
    sim_now        = '0;
    mismatch_count = 0;
    words_sent     = 0;
    actions_seen   = 0;
    run_valid      = 1'b0;
    run_slot       = 0;
    foreach (tab_valid[i]) begin
      tab_valid[i]   = 1'b0;
      tab_done[i]    = 1'b0;
      tab_started[i] = 1'b0;
    end
    foreach (act_hits[i]) act_hits[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_back_to_back();
    test_random_workload();

    $display("sent %0d words, checked %0d result words", words_sent, actions_seen);
    $display("actions seen: start %0d, resume %0d, stop %0d, finish %0d",
             act_hits[ACT_START], act_hits[ACT_RESUME], act_hits[ACT_STOP],
             act_hits[ACT_FINISH]);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ppd_pkg.sv
rtl/ppd_ctrl.sv
rtl/ppd_dpath.sv
rtl/preemptive_priority_dispatcher_unit.sv
bench/testbench.sv
